/* hw/rtl/periodic_curve_sampler_unit_assert.svh */
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef PERIODIC_CURVE_SAMPLER_UNIT_ASSERT_SVH
`define PERIODIC_CURVE_SAMPLER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PCS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PCS_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) trig |=> cons) else $error(msg);
`else
`define PCS_ASSERT(name, prop, msg)
`define PCS_ASSERT_NEXT(name, trig, cons, msg)
`endif
`endif

/* hw/rtl/pcs_pkg.sv */
package pcs_pkg;

  localparam int GRID_DEPTH = 64;
  localparam int IDX_W      = $clog2(GRID_DEPTH);
  localparam int CNT_W      = $clog2(GRID_DEPTH + 1);

  localparam int TIME_W = 31;
  localparam int VAL_W  = 32;
  localparam int DVD_W  = 64;
  localparam int DVS_W  = 31;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_ACK  = 2'd2;

  localparam logic REG_CYCLE = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic              is_query;
    logic              wr_ok;
    logic [5:0]        idx;
    logic [TIME_W-1:0] gt;
    logic [VAL_W-1:0]  cv;
    logic [VAL_W-1:0]  qt;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] cycle;
    logic [6:0]        count;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dvd;
    logic [DVS_W-1:0] dvs;
    logic [6:0]       nbits;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quo;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage

/* hw/rtl/periodic_curve_sampler_unit.sv */
// Periodic curve sampler.
// Input queue: an item is taken when push is high and full is low. A load word
// (req_type 0) writes one table slot; a query word (req_type 1) samples the curve.
// Result queue: the oldest result sits on value_out_o/slope_out_o/status_o while
// empty is low and leaves when pop is high. Every input word gives one result.
// A two-word command queue separates intake from the execution sequencer, and a
// one-word result register holds a finished result, so intake carries on while
// the receiver stalls; execution halts only while a finished result waits for the result register to empty.
// Sequence: a load writes its slot and goes straight to the hand-over. A query runs
// three samples, or only the middle one with a zero grid step. Set-up reads the grid
// step; each sample then wraps its phase on the divider, runs a binary search (up to
// 64 entries), reads the table, multiplies and divides unless it falls on an edge or
// a flat interval, and does its bookkeeping. The slope division and the hand-over
// end a query. The sequencer takes up no new word until the last one is handed over;
// the shared bit-serial divider and the single table read port set the pace.
// Reset empties both queues and loads a period of 65536 and a grid count of 2; the
// table holds no defined contents until loaded. Configure only while idle.
`include "periodic_curve_sampler_unit_assert.svh"

module periodic_curve_sampler_unit import pcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [5:0]  entry_index_i,
  input  logic [30:0] grid_time_i,
  input  logic [31:0] curve_value_i,
  input  logic [31:0] query_time_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] value_out_o,
  output logic [31:0] slope_out_o,
  output logic [1:0]  status_o
);

  logic [30:0] cycle_q;
  logic [6:0]  count_q;
  logic        cfg_we;
  cfg_t        cfg;
  logic        cmd_valid, cmd_pop;
  cmd_t        cmd;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic        out_valid, out_take;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_COUNT) ? {25'b0, count_q} : {1'b0, cycle_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q <= 31'd65536;
      count_q <= 7'd2;
    end else if (cfg_we) begin
      if (paddr[2] == REG_CYCLE) begin
        cycle_q <= pwdata[30:0];
      end else begin
        count_q <= pwdata[6:0];
      end
    end
  end

  assign cfg.cycle = cycle_q;
  assign cfg.count = count_q;

  pcs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .req_type_i    (req_type_i),
    .entry_index_i (entry_index_i),
    .grid_time_i   (grid_time_i),
    .curve_value_i (curve_value_i),
    .query_time_i  (query_time_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  pcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_take = pop && out_valid;
  assign empty    = !out_valid;

  pcs_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o  (out_valid),
    .out_take_i   (out_take),
    .out_value_o  (value_out_o),
    .out_slope_o  (slope_out_o),
    .out_status_o (status_o)
  );

  `PCS_ASSERT(a_pop_has_cmd, cmd_pop |-> cmd_valid, "command taken from empty queue")
  `PCS_ASSERT(a_div_no_restart, div_req.start |-> !div_rsp.busy, "divider restarted mid-run")
  `PCS_ASSERT_NEXT(a_result_kept, !empty && !pop, !empty, "result dropped")

endmodule

/* hw/rtl/pcs_front.sv */
module pcs_front import pcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic        req_type_i,
  input  logic [5:0]  entry_index_i,
  input  logic [30:0] grid_time_i,
  input  logic [31:0] curve_value_i,
  input  logic [31:0] query_time_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  cmd_t       cmd_in;
  logic       wr_en, rd_en;

  always_comb begin
    cmd_in.is_query = (req_type_i == REQ_QUERY);
    cmd_in.wr_ok    = (32'(entry_index_i) < GRID_DEPTH);
    cmd_in.idx      = entry_index_i;
    cmd_in.gt       = grid_time_i;
    cmd_in.cv       = curve_value_i;
    cmd_in.qt       = query_time_i;
  end

  assign full_o      = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    count_d = count_q;
    if (wr_en && !rd_en) begin
      count_d = count_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (wr_en) wr_ptr_q <= !wr_ptr_q;
      if (rd_en) rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) slot_q[wr_ptr_q] <= cmd_in;
  end

endmodule

/* hw/rtl/pcs_div.sv */
module pcs_div import pcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q, done_q;
  logic [6:0]       cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q, rem_q;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             ge;

  assign shifted = {rem_q, dvd_q[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = !diff[DVS_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dvd;
      dvs_q <= req_i.dvs;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* hw/rtl/pcs_core.sv */
module pcs_core import pcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output div_req_t    div_req_o,
  input  div_rsp_t    div_rsp_i,
  output logic        out_valid_o,
  input  logic        out_take_i,
  output logic [31:0] out_value_o,
  output logic [31:0] out_slope_o,
  output logic [1:0]  out_status_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LOAD   = 5'd1;
  localparam logic [4:0] S_G0     = 5'd2;
  localparam logic [4:0] S_G1     = 5'd3;
  localparam logic [4:0] S_DT     = 5'd4;
  localparam logic [4:0] S_MOD    = 5'd5;
  localparam logic [4:0] S_MODW   = 5'd6;
  localparam logic [4:0] S_SRCH   = 5'd7;
  localparam logic [4:0] S_CMP    = 5'd8;
  localparam logic [4:0] S_PICK   = 5'd9;
  localparam logic [4:0] S_RDI    = 5'd10;
  localparam logic [4:0] S_RDI1   = 5'd11;
  localparam logic [4:0] S_MUL0   = 5'd12;
  localparam logic [4:0] S_MUL1   = 5'd13;
  localparam logic [4:0] S_DIV    = 5'd14;
  localparam logic [4:0] S_DIVW   = 5'd15;
  localparam logic [4:0] S_NEXT   = 5'd16;
  localparam logic [4:0] S_SLOPE  = 5'd17;
  localparam logic [4:0] S_SLOPEW = 5'd18;
  localparam logic [4:0] S_OUT    = 5'd19;

  localparam logic [1:0] SAMP_MID   = 2'd0;
  localparam logic [1:0] SAMP_PLUS  = 2'd1;
  localparam logic [1:0] SAMP_MINUS = 2'd2;

  localparam logic [63:0] DELTA_LIM = 64'h4_0000_0000;
  localparam logic [31:0] SAT_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN   = 32'h8000_0000;

  // table: grid time in the upper bits, curve value in the lower
  logic [62:0]       mem_q [GRID_DEPTH];
  logic [62:0]       rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [TIME_W-1:0] rd_g;
  logic [VAL_W-1:0]  rd_v;

  logic [4:0]        state_q, state_d;
  logic [1:0]        samp_q, samp_d;
  logic [31:0]       dt_q, dt_d;
  logic              tneg_q, tneg_d;
  logic [TIME_W-1:0] t_q, t_d, gi_q, gi_d;
  logic [CNT_W-1:0]  lo_q, lo_d, cnt_q, cnt_d;
  logic              edge_q, edge_d;
  logic [31:0]       vi_q, vi_d;
  logic [30:0]       amag_q, amag_d, h_q, h_d;
  logic [31:0]       dmag_q, dmag_d;
  logic              neg_q, neg_d;
  logic [62:0]       prod_q, prod_d;
  logic [31:0]       sv_q [3];
  logic              sv_we;
  logic [31:0]       sv_val;
  logic [31:0]       res_value_q, res_value_d, res_slope_q, res_slope_d;
  logic [1:0]        res_status_q, res_status_d;
  logic              out_valid_q;
  logic [31:0]       out_value_q, out_slope_q;
  logic [1:0]        out_status_q;

  logic [TIME_W-1:0] c_eff;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  step;
  logic [32:0]       dt33, offs, tau, tau_mag;
  logic [TIME_W-1:0] t_wrap;
  logic [31:0]       h_full, a_full;
  logic [32:0]       vdiff, sdiff;
  logic [15:0]       mul_b;
  logic [47:0]       mul_p;
  logic              round_up;
  logic [63:0]       im;
  logic [34:0]       imc;
  logic [35:0]       idelta;
  logic [36:0]       isum;
  logic [31:0]       ival;
  logic [31:0]       sdt_mag;
  logic [31:0]       sdmag;
  logic              sneg;
  logic [31:0]       slope_val;
  logic [31:0]       n_full;

  assign rd_g = rd_q[62:32];
  assign rd_v = rd_q[31:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[IDX_W'(cmd_i.idx)] <= {cmd_i.gt, cmd_i.cv};
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    n_full = 32'(cfg_i.count);
    if (n_full < 32'd2) n_full = 32'd2;
    if (n_full > GRID_DEPTH) n_full = 32'(GRID_DEPTH);
    n_eff = CNT_W'(n_full);
    c_eff = (cfg_i.cycle == '0) ? TIME_W'(1) : cfg_i.cycle;
  end

  assign step = cnt_q >> 1;

  // phase of the current sample point
  always_comb begin
    dt33 = {dt_q[31], dt_q};
    case (samp_q)
      SAMP_PLUS:  offs = dt33;
      SAMP_MINUS: offs = -dt33;
      default:    offs = '0;
    endcase
    tau     = {cmd_i.qt[31], cmd_i.qt} + offs;
    tau_mag = tau[32] ? -tau : tau;
    t_wrap  = (tneg_q && div_rsp_i.rem != '0) ? c_eff - div_rsp_i.rem : div_rsp_i.rem;
  end

  always_comb begin
    h_full = {1'b0, rd_g} - {1'b0, gi_q};
    a_full = {1'b0, t_q} - {1'b0, gi_q};
    vdiff  = {rd_v[31], rd_v} - {vi_q[31], vi_q};
    mul_b  = (state_q == S_MUL0) ? amag_q[15:0] : {1'b0, amag_q[30:16]};
    mul_p  = dmag_q * mul_b;
  end

  // interpolation result: floor, clamp, saturate
  always_comb begin
    round_up = neg_q && (div_rsp_i.rem != '0);
    im       = {1'b0, div_rsp_i.quo[62:0]} + 64'(round_up);
    imc      = (im > DELTA_LIM) ? DELTA_LIM[34:0] : im[34:0];
    idelta   = neg_q ? -{1'b0, imc} : {1'b0, imc};
    isum     = {idelta[35], idelta} + {{5{vi_q[31]}}, vi_q};
    if (isum[36:31] == 6'h00 || isum[36:31] == 6'h3F) begin
      ival = isum[31:0];
    end else begin
      ival = isum[36] ? SAT_MIN : SAT_MAX;
    end
  end

  // slope
  always_comb begin
    sdiff   = {sv_q[SAMP_PLUS][31], sv_q[SAMP_PLUS]} - {sv_q[SAMP_MINUS][31], sv_q[SAMP_MINUS]};
    sdmag   = sdiff[32] ? 32'(-sdiff) : sdiff[31:0];
    sdt_mag = dt_q[31] ? -dt_q : dt_q;
    sneg    = sdiff[32] ^ dt_q[31];
    if (!neg_q) begin
      slope_val = (im > 64'(SAT_MAX)) ? SAT_MAX : im[31:0];
    end else begin
      slope_val = (im > 64'(SAT_MIN)) ? SAT_MIN : -im[31:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    samp_d       = samp_q;
    dt_d         = dt_q;
    tneg_d       = tneg_q;
    t_d          = t_q;
    gi_d         = gi_q;
    lo_d         = lo_q;
    cnt_d        = cnt_q;
    edge_d       = edge_q;
    vi_d         = vi_q;
    amag_d       = amag_q;
    dmag_d       = dmag_q;
    h_d          = h_q;
    neg_d        = neg_q;
    prod_d       = prod_q;
    res_value_d  = res_value_q;
    res_slope_d  = res_slope_q;
    res_status_d = res_status_q;
    rd_addr      = '0;
    mem_we       = 1'b0;
    sv_we        = 1'b0;
    sv_val       = ival;
    cmd_pop_o    = 1'b0;
    div_req_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) state_d = cmd_i.is_query ? S_G0 : S_LOAD;
      end
      S_LOAD: begin
        mem_we       = cmd_i.wr_ok;
        res_value_d  = '0;
        res_slope_d  = '0;
        res_status_d = ST_ACK;
        state_d      = S_OUT;
      end
      S_G0: begin
        state_d = S_G1;
      end
      S_G1: begin
        rd_addr = IDX_W'(1);
        gi_d    = rd_g;
        state_d = S_DT;
      end
      S_DT: begin
        dt_d    = {1'b0, rd_g} - {1'b0, gi_q};
        samp_d  = SAMP_MID;
        state_d = S_MOD;
      end
      S_MOD: begin
        div_req_o.start = 1'b1;
        div_req_o.dvd   = {tau_mag, 31'b0};
        div_req_o.dvs   = c_eff;
        div_req_o.nbits = 7'd33;
        tneg_d          = tau[32];
        state_d         = S_MODW;
      end
      S_MODW: begin
        if (div_rsp_i.done) begin
          t_d     = t_wrap;
          lo_d    = '0;
          cnt_d   = n_eff;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        rd_addr = IDX_W'(lo_q + step);
        state_d = (cnt_q == '0) ? S_PICK : S_CMP;
      end
      S_CMP: begin
        if (!(t_q < rd_g)) begin
          lo_d  = lo_q + step + CNT_W'(1);
          cnt_d = cnt_q - step - CNT_W'(1);
        end else begin
          cnt_d = step;
        end
        state_d = S_SRCH;
      end
      S_PICK: begin
        if (lo_q == '0) begin
          rd_addr = '0;
          edge_d  = 1'b1;
        end else if (lo_q >= n_eff) begin
          rd_addr = IDX_W'(n_eff - CNT_W'(1));
          edge_d  = 1'b1;
        end else begin
          rd_addr = IDX_W'(lo_q - CNT_W'(1));
          edge_d  = 1'b0;
        end
        state_d = S_RDI;
      end
      S_RDI: begin
        gi_d = rd_g;
        vi_d = rd_v;
        if (edge_q) begin
          sv_we   = 1'b1;
          sv_val  = rd_v;
          state_d = S_NEXT;
        end else begin
          rd_addr = IDX_W'(lo_q);
          state_d = S_RDI1;
        end
      end
      S_RDI1: begin
        if (h_full[31] || h_full == '0) begin
          sv_we   = 1'b1;
          sv_val  = vi_q;
          state_d = S_NEXT;
        end else begin
          h_d     = h_full[30:0];
          amag_d  = a_full[31] ? 31'(-a_full) : a_full[30:0];
          dmag_d  = vdiff[32] ? 32'(-vdiff) : vdiff[31:0];
          neg_d   = a_full[31] ^ vdiff[32];
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        prod_d  = 63'(mul_p);
        state_d = S_MUL1;
      end
      S_MUL1: begin
        prod_d  = prod_q + (63'(mul_p) << 16);
        state_d = S_DIV;
      end
      S_DIV: begin
        div_req_o.start = 1'b1;
        div_req_o.dvd   = {prod_q, 1'b0};
        div_req_o.dvs   = h_q;
        div_req_o.nbits = 7'd63;
        state_d         = S_DIVW;
      end
      S_DIVW: begin
        if (div_rsp_i.done) begin
          sv_we   = 1'b1;
          sv_val  = ival;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (samp_q == SAMP_MID && dt_q == '0) begin
          res_value_d  = sv_q[SAMP_MID];
          res_slope_d  = '0;
          res_status_d = ST_ZERO;
          state_d      = S_OUT;
        end else if (samp_q != SAMP_MINUS) begin
          samp_d  = samp_q + 2'd1;
          state_d = S_MOD;
        end else begin
          state_d = S_SLOPE;
        end
      end
      S_SLOPE: begin
        div_req_o.start = 1'b1;
        div_req_o.dvd   = {sdmag, 15'b0, 17'b0};
        div_req_o.dvs   = sdt_mag[30:0];
        div_req_o.nbits = 7'd47;
        neg_d           = sneg;
        state_d         = S_SLOPEW;
      end
      S_SLOPEW: begin
        if (div_rsp_i.done) begin
          res_value_d  = sv_q[SAMP_MID];
          res_slope_d  = slope_val;
          res_status_d = ST_OK;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_take_i) begin
          cmd_pop_o = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_take_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q       <= samp_d;
    dt_q         <= dt_d;
    tneg_q       <= tneg_d;
    t_q          <= t_d;
    gi_q         <= gi_d;
    lo_q         <= lo_d;
    cnt_q        <= cnt_d;
    edge_q       <= edge_d;
    vi_q         <= vi_d;
    amag_q       <= amag_d;
    dmag_q       <= dmag_d;
    h_q          <= h_d;
    neg_q        <= neg_d;
    prod_q       <= prod_d;
    res_value_q  <= res_value_d;
    res_slope_q  <= res_slope_d;
    res_status_q <= res_status_d;
    if (sv_we) sv_q[samp_q] <= sv_val;
    if (cmd_pop_o) begin
      out_value_q  <= res_value_q;
      out_slope_q  <= res_slope_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_slope_o  = out_slope_q;
  assign out_status_o = out_status_q;

endmodule
